// ===== design/dsre_pkg.sv =====
// ============================================================================
// dsre_pkg
// Shared constants, types and address helper for the dual stack rotate engine.
// ============================================================================
package dsre_pkg;

    // Entries per stack memory
    localparam int DEPTH   = 512;
    localparam int ADDR_W  = $clog2(DEPTH);
    // Fill counts reach DEPTH itself
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int SUM_W   = FILL_W + 1;
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 3;
    localparam int CNT_W   = 10;
    localparam int CAP_W   = 10;
    localparam int CMP_W   = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(512);

    // Configuration port
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = PADDR_W'(0);

    // Operation codes on the input channel
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 3'd0,
        KIND_SWAP = 3'd1,
        KIND_PUSH = 3'd2,
        KIND_ROT  = 3'd3,
        KIND_RROT = 3'd4
    } kind_t;

    // Per-stack operations issued by the sequencer
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_PUT  = 3'd1,
        OP_SWAP = 3'd2,
        OP_POP  = 3'd3,
        OP_ROT  = 3'd4,
        OP_RROT = 3'd5
    } stk_op_t;

    typedef struct packed {
        logic              start;
        logic              finish;
        stk_op_t           op;
        logic [DATA_W-1:0] din;
    } stk_cmd_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] top_next;
    } stk_stat_t;

    // Memory position of entry ofs above the bottom at base, wrapping at DEPTH
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [FILL_W-1:0] ofs);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(ofs);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== design/dual_stack_rotate_engine.sv =====
// ============================================================================
// dual_stack_rotate_engine
// Two bounded rotating stacks with load, swap, push, rotate, reverse rotate.
// ============================================================================
// Each item runs a transfer step, then a finishing step. In the transfer
// step the engine checks the request against the fill counts and the
// capacity, issues at most one read and at most one write to each stack
// memory and updates the counts and bottom pointers; in the finishing step,
// which waits while a result is held and not taken, it takes the registered
// read data, writes it back where swap and reverse rotate need it, refreshes
// the cached top entries and loads the result register. No new item is taken
// until the last one has finished. A result waiting in the output register
// does not block the next transfer; a second result waits in the finishing
// step until the first is taken. Stack memories are not cleared after reset
// and need no clearing pass: only entries below the fill count are ever read.
// ============================================================================
module dual_stack_rotate_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dsre_pkg::PADDR_W-1:0]        paddr,
    input  logic [dsre_pkg::PDATA_W-1:0]        pwdata,
    output logic [dsre_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // Item channel
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [dsre_pkg::KIND_W-1:0]         kind,
    input  logic                                stack_select,
    input  logic signed [dsre_pkg::DATA_W-1:0]  load_value,
    // Result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                status,
    output logic signed [dsre_pkg::DATA_W-1:0]  top_a,
    output logic signed [dsre_pkg::DATA_W-1:0]  top_b,
    output logic [dsre_pkg::CNT_W-1:0]          count_a,
    output logic [dsre_pkg::CNT_W-1:0]          count_b
);

    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } state_t;

    state_t                       state_reg;
    logic [dsre_pkg::CAP_W-1:0]   capacity_reg;
    logic                         op_status_reg;
    logic                         result_valid_reg;
    logic                         status_reg;
    logic [dsre_pkg::DATA_W-1:0]  top_a_reg, top_b_reg;
    logic [dsre_pkg::CNT_W-1:0]   count_a_reg, count_b_reg;

    dsre_pkg::stk_cmd_t           cmd_a, cmd_b;
    dsre_pkg::stk_stat_t          stat_a, stat_b;

    logic                         accept;
    logic                         finish;
    logic                         cfg_write;
    logic                         ok;
    logic                         x_has_room;
    logic [dsre_pkg::FILL_W-1:0]  fill_x, fill_y;
    logic [dsre_pkg::DATA_W-1:0]  top_y;
    logic [dsre_pkg::DATA_W-1:0]  din_x;
    dsre_pkg::stk_op_t            op_x, op_y;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == dsre_pkg::ADDR_CAPACITY);
    assign prdata    = (paddr == dsre_pkg::ADDR_CAPACITY)
                       ? dsre_pkg::PDATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= dsre_pkg::CAP_RESET;
        end
        else if (cfg_write)
        begin
            capacity_reg <= pwdata[dsre_pkg::CAP_W-1:0];
        end
    end

    // Handshake
    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign finish     = (state_reg == ST_FINISH) && (!result_valid_reg || result_ready);

    // Acted-on stack is x, the other one is y
    assign fill_x     = stack_select ? stat_b.fill : stat_a.fill;
    assign fill_y     = stack_select ? stat_a.fill : stat_b.fill;
    assign top_y      = stack_select ? stat_a.top  : stat_b.top;
    assign x_has_room = (dsre_pkg::CMP_W'(fill_x) < dsre_pkg::CMP_W'(capacity_reg))
                        && (fill_x < dsre_pkg::FILL_W'(dsre_pkg::DEPTH));

    // Check the request and pick per-stack operations
    always_comb
    begin
        ok    = 1'b0;
        op_x  = dsre_pkg::OP_NONE;
        op_y  = dsre_pkg::OP_NONE;
        din_x = load_value;
        unique case (dsre_pkg::kind_t'(kind))
            dsre_pkg::KIND_LOAD:
            begin
                ok   = x_has_room;
                op_x = dsre_pkg::OP_PUT;
            end
            dsre_pkg::KIND_SWAP:
            begin
                ok   = (fill_x >= dsre_pkg::FILL_W'(2));
                op_x = dsre_pkg::OP_SWAP;
            end
            dsre_pkg::KIND_PUSH:
            begin
                ok    = x_has_room && (fill_y != '0);
                op_x  = dsre_pkg::OP_PUT;
                op_y  = dsre_pkg::OP_POP;
                din_x = top_y;
            end
            dsre_pkg::KIND_ROT:
            begin
                ok   = (fill_x >= dsre_pkg::FILL_W'(2));
                op_x = dsre_pkg::OP_ROT;
            end
            dsre_pkg::KIND_RROT:
            begin
                ok   = (fill_x >= dsre_pkg::FILL_W'(2));
                op_x = dsre_pkg::OP_RROT;
            end
            default:
            begin
            end
        endcase
        if (!ok)
        begin
            op_x = dsre_pkg::OP_NONE;
            op_y = dsre_pkg::OP_NONE;
        end
    end

    // Route commands to the two stacks
    always_comb
    begin
        cmd_a.start  = accept;
        cmd_a.finish = finish;
        cmd_a.op     = stack_select ? op_y : op_x;
        cmd_a.din    = din_x;
        cmd_b.start  = accept;
        cmd_b.finish = finish;
        cmd_b.op     = stack_select ? op_x : op_y;
        cmd_b.din    = din_x;
    end

    dsre_stack u_stack_a (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_a),
        .stat  (stat_a)
    );

    dsre_stack u_stack_b (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_b),
        .stat  (stat_b)
    );

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_status_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            status_reg       <= 1'b0;
            top_a_reg        <= '0;
            top_b_reg        <= '0;
            count_a_reg      <= '0;
            count_b_reg      <= '0;
        end
        else
        begin
            // Drop the result once taken unless a new one replaces it
            if (result_valid_reg && result_ready && !finish)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_status_reg <= !ok;
                        state_reg     <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (finish)
                    begin
                        result_valid_reg <= 1'b1;
                        status_reg       <= op_status_reg;
                        top_a_reg        <= stat_a.top_next;
                        top_b_reg        <= stat_b.top_next;
                        count_a_reg      <= dsre_pkg::CNT_W'(stat_a.fill);
                        count_b_reg      <= dsre_pkg::CNT_W'(stat_b.fill);
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign top_a        = top_a_reg;
    assign top_b        = top_b_reg;
    assign count_a      = count_a_reg;
    assign count_b      = count_b_reg;

    // Every transfer goes on to the finishing step
    a_accept_finish: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_FINISH))
        else $error("transfer not followed by finishing step");

    // Between items an empty stack shows a zero top
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
            ((stat_a.fill != '0 || stat_a.top == '0)
             && (stat_b.fill != '0 || stat_b.top == '0)))
        else $error("empty stack with nonzero cached top");

    // A stalled finishing step leaves the stacks alone
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && result_valid_reg && !result_ready) |=>
            ($stable(stat_a.fill) && $stable(stat_b.fill)
             && (state_reg == ST_FINISH)))
        else $error("stack state moved during output stall");

    // Fill counts never pass the memory depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (stat_a.fill <= dsre_pkg::FILL_W'(dsre_pkg::DEPTH))
        && (stat_b.fill <= dsre_pkg::FILL_W'(dsre_pkg::DEPTH)))
        else $error("fill count beyond memory depth");

endmodule

// ===== design/dsre_ram.sv =====
// ============================================================================
// dsre_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// A read and a write to the same entry in one cycle return the old data.
// ============================================================================
module dsre_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read first, then write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/dsre_stack.sv =====
// ============================================================================
// dsre_stack
// One circular stack: entry memory, fill count, bottom pointer and a cached
// copy of the top entry. Each operation runs a start and a finish step.
// ============================================================================
module dsre_stack (
    input  logic                clk,
    input  logic                rst_n,
    input  dsre_pkg::stk_cmd_t  cmd,
    output dsre_pkg::stk_stat_t stat
);

    logic [dsre_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [dsre_pkg::ADDR_W-1:0] base_reg, base_next;
    logic [dsre_pkg::DATA_W-1:0] top_reg, top_next;
    logic [dsre_pkg::ADDR_W-1:0] wb_addr_reg, wb_addr_next;
    dsre_pkg::stk_op_t           pend_op_reg, pend_op_next;

    logic                        wr_en;
    logic [dsre_pkg::ADDR_W-1:0] wr_addr;
    logic [dsre_pkg::DATA_W-1:0] wr_data;
    logic                        rd_en;
    logic [dsre_pkg::ADDR_W-1:0] rd_addr;
    logic [dsre_pkg::DATA_W-1:0] rd_data;

    logic [dsre_pkg::ADDR_W-1:0] addr_top;
    logic [dsre_pkg::ADDR_W-1:0] addr_below;
    logic [dsre_pkg::ADDR_W-1:0] addr_above;
    logic [dsre_pkg::ADDR_W-1:0] base_dec;
    logic [dsre_pkg::ADDR_W-1:0] base_inc;

    // Positions relative to the current bottom
    assign addr_above = dsre_pkg::slot_addr(base_reg, fill_reg);
    assign addr_top   = dsre_pkg::slot_addr(base_reg,
                            fill_reg - dsre_pkg::FILL_W'(1));
    assign addr_below = dsre_pkg::slot_addr(base_reg,
                            fill_reg - dsre_pkg::FILL_W'(2));
    assign base_inc   = dsre_pkg::slot_addr(base_reg, dsre_pkg::FILL_W'(1));
    assign base_dec   = (base_reg == '0) ? dsre_pkg::ADDR_W'(dsre_pkg::DEPTH - 1)
                                         : base_reg - dsre_pkg::ADDR_W'(1);

    // Decode start and finish steps into memory accesses and state updates
    always_comb
    begin
        wr_en        = 1'b0;
        wr_addr      = addr_above;
        wr_data      = cmd.din;
        rd_en        = 1'b0;
        rd_addr      = addr_below;
        fill_next    = fill_reg;
        base_next    = base_reg;
        top_next     = top_reg;
        wb_addr_next = wb_addr_reg;
        pend_op_next = pend_op_reg;
        if (cmd.start)
        begin
            pend_op_next = cmd.op;
            unique case (cmd.op)
                dsre_pkg::OP_PUT:
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + dsre_pkg::FILL_W'(1);
                    top_next  = cmd.din;
                end
                dsre_pkg::OP_SWAP:
                begin
                    // Old second entry comes back next cycle; top goes below
                    rd_en        = 1'b1;
                    wr_en        = 1'b1;
                    wr_addr      = addr_below;
                    wr_data      = top_reg;
                    wb_addr_next = addr_top;
                end
                dsre_pkg::OP_POP:
                begin
                    fill_next = fill_reg - dsre_pkg::FILL_W'(1);
                    rd_en     = (fill_reg >= dsre_pkg::FILL_W'(2));
                end
                dsre_pkg::OP_ROT:
                begin
                    wr_en     = 1'b1;
                    wr_addr   = base_dec;
                    wr_data   = top_reg;
                    rd_en     = 1'b1;
                    base_next = base_dec;
                end
                dsre_pkg::OP_RROT:
                begin
                    rd_en        = 1'b1;
                    rd_addr      = base_reg;
                    wb_addr_next = addr_above;
                    base_next    = base_inc;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.finish)
        begin
            pend_op_next = dsre_pkg::OP_NONE;
            unique case (pend_op_reg)
                dsre_pkg::OP_SWAP, dsre_pkg::OP_RROT:
                begin
                    wr_en    = 1'b1;
                    wr_addr  = wb_addr_reg;
                    wr_data  = rd_data;
                    top_next = rd_data;
                end
                dsre_pkg::OP_POP:
                begin
                    top_next = (fill_reg == '0) ? '0 : rd_data;
                end
                dsre_pkg::OP_ROT:
                begin
                    top_next = rd_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hold stack control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            base_reg    <= '0;
            top_reg     <= '0;
            wb_addr_reg <= '0;
            pend_op_reg <= dsre_pkg::OP_NONE;
        end
        else
        begin
            fill_reg    <= fill_next;
            base_reg    <= base_next;
            top_reg     <= top_next;
            wb_addr_reg <= wb_addr_next;
            pend_op_reg <= pend_op_next;
        end
    end

    dsre_ram #(
        .DEPTH (dsre_pkg::DEPTH),
        .WIDTH (dsre_pkg::DATA_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign stat.fill     = fill_reg;
    assign stat.top      = top_reg;
    assign stat.top_next = top_next;

endmodule
